// ----- rtl/sht_pkg.sv -----
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types and constants for the sensor hysteresis trigger core.
// ----------------------------------------------------------------------------
`default_nettype none

package sht_pkg;

   localparam int RELAYS       = 4;
   localparam int SENSOR_KINDS = 4;
   localparam int VALUE_BITS   = 32;

   localparam int SLOT_COUNT = RELAYS * SENSOR_KINDS;
   localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CMP_BITS   = VALUE_BITS + 2;
   localparam int FRAC_BITS  = 16;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_WRITE  = 1'b1;

   localparam logic [1:0] MODE_UNKNOWN = 2'd0;
   localparam logic [1:0] MODE_BELOW   = 2'd1;
   localparam logic [1:0] MODE_ABOVE   = 2'd2;
   localparam logic [1:0] MODE_OUTSIDE = 2'd3;

   typedef struct packed {
      logic                  enabled;
      logic [1:0]            mode;
      logic                  turns_off;
      logic [VALUE_BITS-1:0] low;
      logic [VALUE_BITS-1:0] high;
      logic [VALUE_BITS-1:0] band;
   } rule_type;

   typedef struct packed {
      logic triggered;
      logic turn_on;
      logic latch_we;
      logic latch_val;
   } eval_type;

endpackage : sht_pkg

`default_nettype wire

// ----- rtl/sht_eval.sv -----
// ----------------------------------------------------------------------------
// sht_eval
// Evaluates one sample against a rule with hysteresis and the slot latch.
// ----------------------------------------------------------------------------
`default_nettype none

module sht_eval import sht_pkg::*; (
   input  logic [VALUE_BITS-1:0] sample,
   input  rule_type              rule,
   input  logic                  rule_live,
   input  logic                  latch,
   output eval_type              result
);

   logic signed [CMP_BITS-1:0] s_x;
   logic signed [CMP_BITS-1:0] lo_x;
   logic signed [CMP_BITS-1:0] hi_x;
   logic signed [CMP_BITS-1:0] band_x;
   logic signed [CMP_BITS-1:0] h_x;
   logic signed [CMP_BITS-1:0] lo_m;
   logic signed [CMP_BITS-1:0] lo_p;
   logic signed [CMP_BITS-1:0] hi_m;
   logic signed [CMP_BITS-1:0] hi_p;
   logic                       band_pos;
   logic                       active;

   assign s_x    = $signed({{2{sample[VALUE_BITS-1]}}, sample});
   assign lo_x   = $signed({{2{rule.low[VALUE_BITS-1]}}, rule.low});
   assign hi_x   = $signed({{2{rule.high[VALUE_BITS-1]}}, rule.high});
   assign band_x = $signed({{2{rule.band[VALUE_BITS-1]}}, rule.band});

   // non-positive band means one unit
   assign band_pos = !rule.band[VALUE_BITS-1] && (|rule.band);
   assign h_x      = band_pos ? band_x : $signed(CMP_BITS'(1) << FRAC_BITS);

   assign lo_m = lo_x - h_x;
   assign lo_p = lo_x + h_x;
   assign hi_m = hi_x - h_x;
   assign hi_p = hi_x + h_x;

   always_comb begin
      active = 1'b0;
      unique case (rule.mode)
         MODE_BELOW: begin
            if (s_x < lo_m)      active = 1'b1;
            else if (s_x > lo_p) active = 1'b0;
            else                 active = latch;
         end
         MODE_ABOVE: begin
            if (s_x > hi_p)      active = 1'b1;
            else if (s_x < hi_m) active = 1'b0;
            else                 active = latch;
         end
         MODE_OUTSIDE: begin
            if (s_x < lo_m || s_x > hi_p)        active = 1'b1;
            else if (s_x >= lo_p && s_x <= hi_m) active = 1'b0;
            else                                 active = latch;
         end
         default: begin
            active = 1'b0;
         end
      endcase
   end

   assign result.triggered = rule_live && active;
   assign result.turn_on   = rule_live && active && !rule.turns_off;
   assign result.latch_we  = rule_live;
   assign result.latch_val = active;

endmodule : sht_eval

`default_nettype wire

// ----- rtl/sensor_hysteresis_trigger_core.sv -----
// A sample transaction is registered into the s1 stage, then into the output register.
// One transaction per cycle while req_stall is low; writes and samples may alternate freely.
// The rule table sits in a one-port-read, one-port-write synchronous RAM.
// Reset clears the per-slot written bits and hysteresis latches at once;
// no clearing pass, the block accepts transactions the cycle after reset.
// ----------------------------------------------------------------------------
// sensor_hysteresis_trigger_core
// Per-relay, per-sensor-kind threshold comparator with hysteresis latches.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_hysteresis_trigger_core import sht_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [1:0]            req_relay,
   input  logic [1:0]            req_sensor_kind,
   input  logic [VALUE_BITS-1:0] req_sample,
   input  logic                  req_rule_enabled,
   input  logic [1:0]            req_rule_mode,
   input  logic                  req_rule_turns_off,
   input  logic [VALUE_BITS-1:0] req_rule_low,
   input  logic [VALUE_BITS-1:0] req_rule_high,
   input  logic [VALUE_BITS-1:0] req_rule_band,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_triggered,
   output logic                  rsp_turn_on
);

   rule_type                rule_mem [SLOT_COUNT];
   rule_type                rd_rule_ff;
   logic [SLOT_COUNT-1:0]   written_ff;
   logic [SLOT_COUNT-1:0]   latch_ff;
   logic [SLOT_COUNT-1:0]   latch_in;

   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic                    s1_live_ff;
   logic [SLOT_BITS-1:0]    s1_addr_ff;
   logic [VALUE_BITS-1:0]   s1_sample_ff;

   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic                    out_trig_ff;
   logic                    out_on_ff;

   logic                    accept;
   logic                    accept_wr;
   logic                    accept_rd;
   logic                    in_range;
   logic [SLOT_BITS-1:0]    addr;
   logic                    advance;
   rule_type                wr_rule;
   eval_type                eval;

   assign in_range = (32'(req_relay) < RELAYS) && (32'(req_sensor_kind) < SENSOR_KINDS);
   assign addr     = SLOT_BITS'(32'(req_relay) * SENSOR_KINDS + 32'(req_sensor_kind));

   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign accept_wr = accept && (req_func == FUNC_WRITE);
   assign accept_rd = accept && (req_func == FUNC_SAMPLE);

   assign wr_rule.enabled   = req_rule_enabled;
   assign wr_rule.mode      = req_rule_mode;
   assign wr_rule.turns_off = req_rule_turns_off;
   assign wr_rule.low       = req_rule_low;
   assign wr_rule.high      = req_rule_high;
   assign wr_rule.band      = req_rule_band;

   // rule RAM: write on a rule transaction, registered read on a sample
   always_ff @(posedge clock) begin
      if (accept_wr && in_range) begin
         rule_mem[addr] <= wr_rule;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_rd) begin
         rd_rule_ff <= rule_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (accept_wr && in_range) begin
         written_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_rd) begin
         s1_live_ff   <= in_range && written_ff[addr];
         s1_addr_ff   <= addr;
         s1_sample_ff <= req_sample;
      end
   end

   sht_eval u_eval (
      .sample    (s1_sample_ff),
      .rule      (rd_rule_ff),
      .rule_live (s1_live_ff && rd_rule_ff.enabled),
      .latch     (latch_ff[s1_addr_ff]),
      .result    (eval)
   );

   always_comb begin
      latch_in = latch_ff;
      if (advance && eval.latch_we) begin
         latch_in[s1_addr_ff] = eval.latch_val;
      end
   end

   assign s1_valid_in  = accept_rd ? 1'b1 : (s1_valid_ff && !advance);
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         latch_ff     <= latch_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_trig_ff <= eval.triggered;
         out_on_ff   <= eval.turn_on;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_triggered = out_trig_ff;
   assign rsp_turn_on   = out_on_ff;

`ifndef SYNTH
   a_wr_no_rsp : assert property (@(posedge clock) disable iff (reset)
      accept_wr |=> !s1_valid_ff)
      else $error("rule write entered the response path");

   a_rd_enters : assert property (@(posedge clock) disable iff (reset)
      accept_rd |=> s1_valid_ff)
      else $error("sample transaction lost before evaluation");

   a_on_trig : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_turn_on || rsp_triggered))
      else $error("turn_on without trigger");

   a_latch_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(latch_ff))
      else $error("latch changed without an evaluation");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && s1_valid_ff) |-> req_stall)
      else $error("pipeline accepted into a full stage");
`endif

endmodule : sensor_hysteresis_trigger_core

`default_nettype wire
